// ===== rtl/xmodem_block_receiver_core_defines.svh =====
// Assertion helpers shared by the receiver RTL.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef XMODEM_BLOCK_RECEIVER_CORE_DEFINES_SVH
`define XMODEM_BLOCK_RECEIVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XBR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xbr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define XBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xbr assertion failed");

`endif

// ===== rtl/xbr_pkg.sv =====
`timescale 1ns / 1ps

package xbr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int IDX_W       = $clog2(BLOCK_BYTES + 1);

  localparam logic [7:0]  X_SOH    = 8'd1;
  localparam logic [7:0]  X_EOT    = 8'd4;
  localparam logic [7:0]  X_ACK    = 8'd6;
  localparam logic [7:0]  X_NACK   = 8'd21;
  localparam logic [7:0]  X_CAN    = 8'd24;
  localparam logic [7:0]  INVITE_C = 8'h43;
  localparam logic [7:0]  TMO_BYTE = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [3:0] RETRY_LIMIT_RESET     = 4'd10;
  localparam logic [5:0] HANDSHAKE_TRIES_RESET = 6'd16;
  localparam logic [3:0] RETRY_MAX             = 4'd15;

  localparam logic [1:0] CFG_RETRY_LIMIT     = 2'd0;
  localparam logic [1:0] CFG_HANDSHAKE_TRIES = 2'd1;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_START   = 2'd2,
    CMD_IGNORE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_KEEP   = 2'd1,
    EV_DUP    = 2'd2,
    EV_REJECT = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_SUCCESS    = 3'd1,
    ST_MAX_RETRY  = 3'd2,
    ST_CANCELLED  = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_NO_SENDER  = 3'd5
  } status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

endpackage

// ===== rtl/xbr_in_if.sv =====
`timescale 1ns / 1ps

interface xbr_in_if;
  import xbr_pkg::*;

  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

// ===== rtl/xbr_out_if.sv =====
`timescale 1ns / 1ps

interface xbr_out_if;
  import xbr_pkg::*;

  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  event_t     block_event;
  logic       done_res;
  status_t    status;
  logic       last;

  modport source (
    output valid, output tx_valid, output tx_byte, output data_valid,
    output data_byte, output block_event, output done_res, output status,
    output last, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input data_valid,
    input data_byte, input block_event, input done_res, input status,
    input last, output ready
  );
endinterface

// ===== rtl/xbr_cfg_if.sv =====
`timescale 1ns / 1ps

interface xbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/xmodem_block_receiver_core.sv =====
// XMODEM block receiver with CRC-16 and 8-bit checksum fallback.
// rx_in carries one event word per cycle: a received byte, a receive timeout
// or a start request. res_out carries result words: a byte to send back to
// the sender, a payload byte, a block verdict, and the transfer status with
// a last flag on the final word caused by one event. cfg writes the retry
// limit (index 0) and the handshake tries (index 1); it is always ready.
// An accepted event is held in an input register and processed in a single
// pass as it leaves that register, when its results load the output
// register, from which the first result word is offered.
// Most events cause zero or one word, so one event is taken every cycle
// unless res_out stalls. A cancel sequence causes three words and holds the
// output register until all are taken; events that cause no word still pass
// meanwhile, and the next event causing a word waits in the input register.
// When res_out stalls, the output register holds its word and an event that
// causes a word waits in the input register, so rx_in.ready drops until the
// output can take new results.
// Synchronous reset returns the receiver to idle with CRC mode, block one,
// cleared retries and the reset register values; no words are pending.
`timescale 1ns / 1ps
`include "xmodem_block_receiver_core_defines.svh"

module xmodem_block_receiver_core (
  input logic     clk,
  input logic     rst,
  xbr_in_if.sink  rx_in,
  xbr_out_if.source res_out,
  xbr_cfg_if.sink cfg
);
  import xbr_pkg::*;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b0000000001,
    PH_INVITE = 10'b0000000010,
    PH_CMD    = 10'b0000000100,
    PH_NUM    = 10'b0000001000,
    PH_INV    = 10'b0000010000,
    PH_DATA   = 10'b0000100000,
    PH_CHK1   = 10'b0001000000,
    PH_CHK2   = 10'b0010000000,
    PH_CAN2   = 10'b0100000000,
    PH_DONE   = 10'b1000000000
  } phase_t;

  logic [3:0] retry_limit;
  logic [5:0] handshake_tries;

  logic       in_full;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       move;

  phase_t           phase, phase_next;
  logic             crc_mode, crc_mode_next;
  logic [5:0]       invite_count, invite_count_next;
  logic [7:0]       expected_block, expected_block_next;
  logic [3:0]       retry_count, retry_count_next;
  logic [7:0]       header_number, header_number_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       crc_high_byte, crc_high_byte_next;
  logic             duplicate_flag, duplicate_flag_next;
  status_t          status, status_next;

  logic [1:0] r_cnt;
  logic       r_txv;
  logic [7:0] r_txb;
  logic       r_dv;
  logic [7:0] r_db;
  event_t     r_ev;

  logic             tmo;
  logic [7:0]       v;
  logic [3:0]       retry_bump;
  logic             retry_hit;
  logic [5:0]       hs_lim;
  logic [IDX_W-1:0] idx_inc;
  logic             comp;
  logic             check_ok;
  logic             do_hdr;
  logic             do_unexp;
  logic             do_nak;

  logic [1:0] o_cnt;
  logic       o_txv;
  logic [7:0] o_txb;
  logic       o_dv;
  logic [7:0] o_db;
  event_t     o_ev;
  logic       o_done;
  status_t    o_status;
  logic       out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit     <= RETRY_LIMIT_RESET;
      handshake_tries <= HANDSHAKE_TRIES_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RETRY_LIMIT:     retry_limit <= cfg.data[3:0];
        CFG_HANDSHAKE_TRIES: handshake_tries <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  assign out_free    = (o_cnt == 2'd0) || (o_cnt == 2'd1 && res_out.ready);
  assign move        = in_full && (r_cnt == 2'd0 || out_free);
  assign rx_in.ready = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_in.ready) begin
      in_full <= rx_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_in.valid && rx_in.ready) begin
      in_cmd  <= rx_in.command;
      in_byte <= rx_in.rx_byte;
    end
  end

  always_comb begin
    phase_next          = phase;
    crc_mode_next       = crc_mode;
    invite_count_next   = invite_count;
    expected_block_next = expected_block;
    retry_count_next    = retry_count;
    header_number_next  = header_number;
    byte_index_next     = byte_index;
    running_crc_next    = running_crc;
    running_sum_next    = running_sum;
    crc_high_byte_next  = crc_high_byte;
    duplicate_flag_next = duplicate_flag;
    status_next         = status;
    r_cnt    = 2'd0;
    r_txv    = 1'b0;
    r_txb    = 8'd0;
    r_dv     = 1'b0;
    r_db     = 8'd0;
    r_ev     = EV_NONE;
    do_hdr   = 1'b0;
    do_unexp = 1'b0;
    do_nak   = 1'b0;

    tmo        = (in_cmd == CMD_TIMEOUT);
    v          = tmo ? TMO_BYTE : in_byte;
    retry_bump = (retry_count == RETRY_MAX) ? retry_count : retry_count + 4'd1;
    retry_hit  = (retry_bump >= retry_limit);
    hs_lim     = (handshake_tries == 6'd0) ? 6'd1 : handshake_tries;
    idx_inc    = byte_index + IDX_W'(1);
    comp       = (v == ~header_number);
    check_ok   = crc_mode ? ({crc_high_byte, v} == running_crc) : (v == running_sum);

    case (in_cmd)
      CMD_START: begin
        phase_next          = PH_INVITE;
        crc_mode_next       = 1'b1;
        invite_count_next   = 6'd1;
        expected_block_next = 8'd1;
        retry_count_next    = 4'd0;
        duplicate_flag_next = 1'b0;
        byte_index_next     = '0;
        status_next         = ST_BUSY;
        r_cnt = 2'd1;
        r_txv = 1'b1;
        r_txb = INVITE_C;
      end
      CMD_BYTE, CMD_TIMEOUT: begin
        case (phase)
          PH_INVITE: begin
            if (!tmo) begin
              do_hdr = 1'b1;
            end else if (invite_count < hs_lim) begin
              invite_count_next = invite_count + 6'd1;
              r_cnt = 2'd1;
              r_txv = 1'b1;
              r_txb = crc_mode ? INVITE_C : X_NACK;
            end else if (crc_mode) begin
              crc_mode_next     = 1'b0;
              invite_count_next = 6'd1;
              r_cnt = 2'd1;
              r_txv = 1'b1;
              r_txb = X_NACK;
            end else begin
              phase_next  = PH_DONE;
              status_next = ST_NO_SENDER;
            end
          end
          PH_CMD: begin
            if (tmo) begin
              do_unexp = 1'b1;
            end else begin
              do_hdr = 1'b1;
            end
          end
          PH_NUM: begin
            header_number_next = v;
            phase_next         = PH_INV;
          end
          PH_INV: begin
            duplicate_flag_next = 1'b0;
            if (comp && header_number == expected_block - 8'd1) begin
              duplicate_flag_next = 1'b1;
              phase_next          = PH_DATA;
            end else if (comp && header_number == expected_block) begin
              phase_next = PH_DATA;
            end else begin
              do_nak = 1'b1;
            end
          end
          PH_DATA: begin
            if (tmo) begin
              do_nak = 1'b1;
            end else begin
              r_cnt = 2'd1;
              r_dv  = 1'b1;
              r_db  = in_byte;
              running_crc_next = crc16_byte(running_crc, in_byte);
              running_sum_next = running_sum + in_byte;
              byte_index_next  = idx_inc;
              if (idx_inc >= IDX_W'(BLOCK_BYTES)) begin
                phase_next = crc_mode ? PH_CHK1 : PH_CHK2;
              end
            end
          end
          PH_CHK1: begin
            crc_high_byte_next = v;
            phase_next         = PH_CHK2;
          end
          PH_CHK2: begin
            if (!check_ok) begin
              do_nak = 1'b1;
            end else begin
              r_cnt = 2'd1;
              r_txv = 1'b1;
              r_txb = X_ACK;
              r_ev  = duplicate_flag ? EV_DUP : EV_KEEP;
              if (!duplicate_flag) begin
                expected_block_next = expected_block + 8'd1;
              end
              phase_next = PH_CMD;
            end
          end
          PH_CAN2: begin
            r_txv = 1'b1;
            r_txb = X_CAN;
            phase_next = PH_DONE;
            if (!tmo && in_byte == X_CAN) begin
              r_cnt       = 2'd1;
              r_txb       = X_ACK;
              status_next = ST_CANCELLED;
            end else begin
              r_cnt       = 2'd3;
              status_next = ST_UNKNOWN;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (do_hdr) begin
      if (in_byte == X_SOH) begin
        phase_next       = PH_NUM;
        byte_index_next  = '0;
        running_crc_next = 16'd0;
        running_sum_next = 8'd0;
      end else if (in_byte == X_EOT) begin
        r_cnt       = 2'd1;
        r_txv       = 1'b1;
        r_txb       = X_ACK;
        phase_next  = PH_DONE;
        status_next = ST_SUCCESS;
      end else if (in_byte == X_CAN) begin
        phase_next = PH_CAN2;
      end else begin
        phase_next = PH_CMD;
        do_unexp   = 1'b1;
      end
    end

    if (do_unexp) begin
      retry_count_next = retry_bump;
      if (retry_hit) begin
        r_cnt       = 2'd3;
        r_txv       = 1'b1;
        r_txb       = X_CAN;
        phase_next  = PH_DONE;
        status_next = ST_MAX_RETRY;
      end
    end

    if (do_nak) begin
      r_cnt            = 2'd1;
      r_txv            = 1'b1;
      r_txb            = X_NACK;
      r_ev             = EV_REJECT;
      retry_count_next = retry_bump;
      if (retry_hit) begin
        phase_next  = PH_DONE;
        status_next = ST_MAX_RETRY;
      end else begin
        phase_next = PH_CMD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      crc_mode       <= 1'b1;
      invite_count   <= 6'd0;
      expected_block <= 8'd1;
      retry_count    <= 4'd0;
      header_number  <= 8'd0;
      byte_index     <= '0;
      running_crc    <= 16'd0;
      running_sum    <= 8'd0;
      crc_high_byte  <= 8'd0;
      duplicate_flag <= 1'b0;
      status         <= ST_BUSY;
    end else if (move) begin
      phase          <= phase_next;
      crc_mode       <= crc_mode_next;
      invite_count   <= invite_count_next;
      expected_block <= expected_block_next;
      retry_count    <= retry_count_next;
      header_number  <= header_number_next;
      byte_index     <= byte_index_next;
      running_crc    <= running_crc_next;
      running_sum    <= running_sum_next;
      crc_high_byte  <= crc_high_byte_next;
      duplicate_flag <= duplicate_flag_next;
      status         <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= 2'd0;
    end else if (move && r_cnt != 2'd0) begin
      o_cnt <= r_cnt;
    end else if (res_out.valid && res_out.ready) begin
      o_cnt <= o_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && r_cnt != 2'd0) begin
      o_txv    <= r_txv;
      o_txb    <= r_txb;
      o_dv     <= r_dv;
      o_db     <= r_db;
      o_ev     <= r_ev;
      o_done   <= (phase_next == PH_DONE);
      o_status <= status_next;
    end
  end

  assign res_out.valid       = (o_cnt != 2'd0);
  assign res_out.tx_valid    = o_txv;
  assign res_out.tx_byte     = o_txb;
  assign res_out.data_valid  = o_dv;
  assign res_out.data_byte   = o_db;
  assign res_out.block_event = o_ev;
  assign res_out.done_res    = o_done;
  assign res_out.status      = o_status;
  assign res_out.last        = (o_cnt == 2'd1);

  `XBR_ASSERT_SAME(a_done_has_status, phase == PH_DONE, status != ST_BUSY)
  `XBR_ASSERT_SAME(a_invite_counted, phase == PH_INVITE, invite_count != 6'd0)
  `XBR_ASSERT_SAME(a_index_in_block, phase == PH_DATA, byte_index < IDX_W'(BLOCK_BYTES))
  `XBR_ASSERT_NEXT(a_last_word_drains,
                   res_out.valid && res_out.ready && o_cnt == 2'd1 && !move,
                   !res_out.valid)

endmodule

// ===== tb/sv/xbr_checker.sv =====
`timescale 1ns / 1ps

package xbr_tb_pkg;
  import xbr_pkg::*;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module xbr_checker (
  input  logic clk,
  input  logic rst,
  xbr_in_if    rx,
  xbr_out_if   res,
  xbr_cfg_if   cfg,
  output int   fail_count,
  output int   words_pending
);
  import xbr_pkg::*;
  import xbr_tb_pkg::*;

  typedef enum logic [3:0] {
    RX_IDLE, RX_INVITE, RX_HEADER, RX_NUMBER, RX_COMPLEMENT,
    RX_PAYLOAD, RX_CHECK_HI, RX_CHECK_LO, RX_CANCEL2, RX_DONE
  } rx_phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    event_t     block_event;
    logic       done_res;
    status_t    status;
    logic       last;
  } result_word_t;

  result_word_t expected_words[$];
  result_word_t item_words[$];

  logic [3:0]  retry_lim;
  logic [5:0]  tries;
  rx_phase_t   rx_phase;
  logic        crc_mode;
  logic [6:0]  invites;
  logic [7:0]  expected_block;
  logic [3:0]  retries;
  logic [7:0]  header_number;
  int          byte_count;
  logic [15:0] block_crc;
  logic [7:0]  block_sum;
  logic [7:0]  check_hi;
  logic        duplicate;
  status_t     xfer_status;

  function automatic void emit(input logic tv, input logic [7:0] tb, input logic dv,
                               input logic [7:0] db, input event_t ev);
    result_word_t w;
    if (item_words.size() < 3) begin
      w = '0;
      w.tx_valid = tv;
      w.tx_byte = tb;
      w.data_valid = dv;
      w.data_byte = db;
      w.block_event = ev;
      item_words.push_back(w);
    end
  endfunction

  function automatic void end_transfer(input status_t st);
    rx_phase = RX_DONE;
    xfer_status = st;
  endfunction

  function automatic void bump_retries();
    if (retries < RETRY_MAX) begin
      retries = retries + 4'd1;
    end
  endfunction

  function automatic void send_cancel(input status_t st);
    repeat (3) emit(1'b1, X_CAN, 1'b0, 8'h00, EV_NONE);
    end_transfer(st);
  endfunction

  function automatic void reject_block();
    emit(1'b1, X_NACK, 1'b0, 8'h00, EV_REJECT);
    bump_retries();
    if (retries >= retry_lim) begin
      end_transfer(ST_MAX_RETRY);
    end else begin
      rx_phase = RX_HEADER;
    end
  endfunction

  function automatic void stray_input();
    bump_retries();
    if (retries >= retry_lim) begin
      send_cancel(ST_MAX_RETRY);
    end
  endfunction

  function automatic void take_header(input logic [7:0] b);
    if (b == X_SOH) begin
      rx_phase = RX_NUMBER;
      byte_count = 0;
      block_crc = '0;
      block_sum = '0;
    end else if (b == X_EOT) begin
      emit(1'b1, X_ACK, 1'b0, 8'h00, EV_NONE);
      end_transfer(ST_SUCCESS);
    end else if (b == X_CAN) begin
      rx_phase = RX_CANCEL2;
    end else begin
      rx_phase = RX_HEADER;
      stray_input();
    end
  endfunction

  function automatic void check_block(input logic [7:0] b);
    logic ok;
    ok = crc_mode ? ({check_hi, b} == block_crc) : (b == block_sum);
    if (!ok) begin
      reject_block();
    end else begin
      if (duplicate) begin
        emit(1'b1, X_ACK, 1'b0, 8'h00, EV_DUP);
      end else begin
        emit(1'b1, X_ACK, 1'b0, 8'h00, EV_KEEP);
        expected_block = expected_block + 8'd1;
      end
      rx_phase = RX_HEADER;
    end
  endfunction

  function automatic void invite_timeout();
    logic [6:0] lim;
    lim = (tries == 6'd0) ? 7'd1 : {1'b0, tries};
    if (invites < lim) begin
      invites = invites + 7'd1;
      emit(1'b1, crc_mode ? INVITE_C : X_NACK, 1'b0, 8'h00, EV_NONE);
    end else if (crc_mode) begin
      crc_mode = 1'b0;
      invites = 7'd1;
      emit(1'b1, X_NACK, 1'b0, 8'h00, EV_NONE);
    end else begin
      end_transfer(ST_NO_SENDER);
    end
  endfunction

  function automatic void predict_item(input cmd_t cmd, input logic [7:0] b);
    logic [7:0] v;
    logic       tmo;
    logic       comp;
    tmo = (cmd == CMD_TIMEOUT);
    v = tmo ? TMO_BYTE : b;
    item_words.delete();
    if (cmd == CMD_START) begin
      rx_phase = RX_INVITE;
      crc_mode = 1'b1;
      invites = 7'd1;
      expected_block = 8'd1;
      retries = '0;
      duplicate = 1'b0;
      byte_count = 0;
      xfer_status = ST_BUSY;
      emit(1'b1, INVITE_C, 1'b0, 8'h00, EV_NONE);
    end else if (cmd == CMD_BYTE || tmo) begin
      case (rx_phase)
        RX_INVITE: begin
          if (tmo) invite_timeout();
          else take_header(b);
        end
        RX_HEADER: begin
          if (tmo) stray_input();
          else take_header(b);
        end
        RX_NUMBER: begin
          header_number = v;
          rx_phase = RX_COMPLEMENT;
        end
        RX_COMPLEMENT: begin
          comp = (v == 8'hFF - header_number);
          duplicate = 1'b0;
          if (comp && header_number == expected_block - 8'd1) begin
            duplicate = 1'b1;
            rx_phase = RX_PAYLOAD;
          end else if (comp && header_number == expected_block) begin
            rx_phase = RX_PAYLOAD;
          end else begin
            reject_block();
          end
        end
        RX_PAYLOAD: begin
          if (tmo) begin
            reject_block();
          end else begin
            emit(1'b0, 8'h00, 1'b1, b, EV_NONE);
            block_crc = crc16_update(block_crc, b);
            block_sum = block_sum + b;
            byte_count++;
            if (byte_count >= BLOCK_BYTES) begin
              rx_phase = crc_mode ? RX_CHECK_HI : RX_CHECK_LO;
            end
          end
        end
        RX_CHECK_HI: begin
          check_hi = v;
          rx_phase = RX_CHECK_LO;
        end
        RX_CHECK_LO: check_block(v);
        RX_CANCEL2: begin
          if (!tmo && b == X_CAN) begin
            emit(1'b1, X_ACK, 1'b0, 8'h00, EV_NONE);
            end_transfer(ST_CANCELLED);
          end else begin
            send_cancel(ST_UNKNOWN);
          end
        end
        default: ;
      endcase
    end
    foreach (item_words[k]) begin
      item_words[k].done_res = (rx_phase == RX_DONE);
      item_words[k].status = xfer_status;
      item_words[k].last = (k == item_words.size() - 1);
      expected_words.push_back(item_words[k]);
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_word();
    result_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word arrived with no prediction pending");
      fail_count++;
    end else begin
      want = expected_words.pop_front();
      check_field("tx_valid", 8'(want.tx_valid), 8'(res.tx_valid));
      check_field("tx_byte", want.tx_byte, res.tx_byte);
      check_field("data_valid", 8'(want.data_valid), 8'(res.data_valid));
      check_field("data_byte", want.data_byte, res.data_byte);
      check_field("block_event", 8'(want.block_event), 8'(res.block_event));
      check_field("done_res", 8'(want.done_res), 8'(res.done_res));
      check_field("status", 8'(want.status), 8'(res.status));
      check_field("last", 8'(want.last), 8'(res.last));
    end
  endtask

  initial begin
    fail_count = 0;
    words_pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      retry_lim = RETRY_LIMIT_RESET;
      tries = HANDSHAKE_TRIES_RESET;
      rx_phase = RX_IDLE;
      crc_mode = 1'b1;
      invites = '0;
      expected_block = 8'd1;
      retries = '0;
      header_number = '0;
      byte_count = 0;
      block_crc = '0;
      block_sum = '0;
      check_hi = '0;
      duplicate = 1'b0;
      xfer_status = ST_BUSY;
      expected_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_RETRY_LIMIT) retry_lim = cfg.data[3:0];
        else if (cfg.index == CFG_HANDSHAKE_TRIES) tries = cfg.data[5:0];
      end
      if (rx.valid && rx.ready) begin
        predict_item(rx.command, rx.rx_byte);
      end
      if (res.valid && res.ready) begin
        compare_word();
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import xbr_pkg::*;

  localparam int GAP_MAX      = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 10;

  typedef enum int {
    FR_GOOD, FR_DUP, FR_BAD_CHECK, FR_BAD_COMP, FR_BAD_NUM, FR_DATA_TMO, FR_NOISE
  } frame_kind_t;

  logic clk;
  logic rst = 1'b1;
  int   fail_count;
  int   words_pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  bit   no_idle = 1'b0;
  bit   hold_request = 1'b0;
  bit   use_crc = 1'b1;
  logic [7:0] next_block = 8'd1;
  logic [5:0] tries_now = HANDSHAKE_TRIES_RESET;

  xbr_in_if  rx_if ();
  xbr_out_if res_if ();
  xbr_cfg_if cfg_if ();

  xmodem_block_receiver_core dut (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_if),
    .res_out (res_if),
    .cfg     (cfg_if)
  );

  xbr_checker chk (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_if),
    .res           (res_if),
    .cfg           (cfg_if),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side may stall before each word, and once holds off for a long stretch.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = hold_request ? HOLD_CYCLES : (no_idle ? 0 : $urandom_range(0, GAP_MAX));
      hold_request = 1'b0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.command <= cmd;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    rx_if.valid <= 1'b0;
    wait (words_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] retry, input logic [5:0] tries);
    wait_drain();
    write_reg(CFG_RETRY_LIMIT, {4'($urandom_range(0, 15)), retry});
    write_reg(CFG_HANDSHAKE_TRIES, {2'($urandom_range(0, 3)), tries});
    cfg_if.valid <= 1'b0;
    tries_now = tries;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  num;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [15:0] crc;
    int          count;
    int          c;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 3)) begin
        c = $urandom_range(0, 2);
        send_item((c == 2) ? CMD_IGNORE : cmd_t'(c), 8'($urandom));
      end
    end else begin
      num = next_block;
      if (kind == FR_DUP) num = next_block - 8'd1;
      if (kind == FR_BAD_NUM) num = next_block + 8'($urandom_range(1, 253));
      send_item(CMD_BYTE, X_SOH);
      send_item(CMD_BYTE, num);
      if (kind == FR_BAD_COMP) send_item(CMD_BYTE, (8'hFF - num) ^ 8'($urandom_range(1, 255)));
      else send_item(CMD_BYTE, 8'hFF - num);
      if (kind != FR_BAD_COMP && kind != FR_BAD_NUM) begin
        count = BLOCK_BYTES;
        if (kind == FR_DATA_TMO) begin
          count = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, BLOCK_BYTES - 1);
        end
        crc = '0;
        sum = '0;
        repeat (count) begin
          b = 8'($urandom);
          send_item(CMD_BYTE, b);
          crc = crc16_byte(crc, b);
          sum = sum + b;
        end
        if (kind == FR_DATA_TMO) begin
          send_item(CMD_TIMEOUT, 8'($urandom));
        end else begin
          if (kind == FR_BAD_CHECK) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
            sum = sum ^ 8'($urandom_range(1, 255));
          end
          if (use_crc) send_item(CMD_BYTE, crc[15:8]);
          if ($urandom_range(0, 3) == 0) send_item(CMD_TIMEOUT, 8'($urandom));
          else send_item(CMD_BYTE, use_crc ? crc[7:0] : sum);
          if (kind == FR_GOOD) next_block = next_block + 8'd1;
        end
      end
    end
  endtask

  task automatic run_session();
    int lim;
    int k;
    int r;
    logic [7:0] b;
    lim = (tries_now == 6'd0) ? 1 : int'(tries_now);
    send_item(CMD_START, 8'($urandom));
    next_block = 8'd1;
    r = $urandom_range(0, 19);
    if (r < 13) k = $urandom_range(0, (lim > 3) ? 2 : lim - 1);
    else if (r < 19) k = $urandom_range(lim, 2 * lim - 1);
    else k = 2 * lim;
    repeat (k) send_item(CMD_TIMEOUT, 8'($urandom));
    use_crc = (k < lim);
    if (k < 2 * lim) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 7) == 0) wait_drain();
        r = $urandom_range(0, 15);
        if (r < 3) send_frame(FR_GOOD);
        else if (r == 3) send_frame(FR_DUP);
        else if (r == 4) send_frame(FR_BAD_CHECK);
        else if (r < 7) send_frame(FR_BAD_COMP);
        else if (r < 9) send_frame(FR_BAD_NUM);
        else if (r < 12) send_frame(FR_DATA_TMO);
        else send_frame(FR_NOISE);
      end
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send_item(CMD_BYTE, X_EOT);
      end else if (r == 6) begin
        send_item(CMD_BYTE, X_CAN);
        send_item(CMD_BYTE, X_CAN);
      end else if (r == 7) begin
        send_item(CMD_BYTE, X_CAN);
        b = 8'($urandom);
        if (b == X_CAN) b = 8'h00;
        if ($urandom_range(0, 1)) send_item(CMD_TIMEOUT, 8'($urandom));
        else send_item(CMD_BYTE, b);
      end
    end
  endtask

  task automatic run_directed();
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_IGNORE, 8'hA5);
    send_item(CMD_START, 8'h5A);
    send_item(CMD_TIMEOUT, 8'hFF);
    send_item(CMD_IGNORE, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_BYTE, X_SOH);
    send_item(CMD_BYTE, 8'h05);
    send_item(CMD_BYTE, 8'hFA);
    send_item(CMD_BYTE, X_SOH);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, X_SOH);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_BYTE, 8'hFE);
    send_item(CMD_BYTE, 8'hAA);
    send_item(CMD_TIMEOUT, 8'h55);
    send_item(CMD_BYTE, X_CAN);
    send_item(CMD_BYTE, X_CAN);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, X_CAN);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, X_EOT);
  endtask

  initial begin
    logic [3:0] retry_set [PHASES];
    logic [5:0] tries_set [PHASES];
    int         phase_start;
    retry_set = '{4'd15, 4'd1, 4'd6, 4'd10, 4'd15};
    tries_set = '{6'd1, 6'd63, 6'd0, 6'd16, 6'd1};
    rx_if.valid = 1'b0;
    rx_if.command = CMD_BYTE;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_RETRY_LIMIT;
    cfg_if.data = 8'h00;
    no_idle = 1'b1;
    hold_request = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    no_idle = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        set_config(4'($urandom_range(1, 15)), 6'($urandom_range(0, 63)));
      end else begin
        set_config(retry_set[p], tries_set[p]);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        run_session();
      end
      no_idle = 1'b0;
    end
    wait_drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/xbr_pkg.sv
rtl/xbr_in_if.sv
rtl/xbr_out_if.sv
rtl/xbr_cfg_if.sv
rtl/xmodem_block_receiver_core.sv
tb/sv/xbr_checker.sv
tb/sv/tb.sv
